>>> rtl/core/ordered_list_delete_at_position_defines.svh
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_DELETE_AT_POSITION_DEFINES_SVH
`define ORDERED_LIST_DELETE_AT_POSITION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/olist_pkg.sv
// Widths, codes and types of the ordered list block.
`default_nettype none

package olist_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [STAT_W-1:0]       status_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  localparam value_t NEG_ONE = -32'sd1;

endpackage

`default_nettype wire

>>> rtl/core/olist_in_if.sv
// Input channel of the ordered list: append or delete requests.
`default_nettype none

interface olist_in_if;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  olist_pkg::value_t     value;
  olist_pkg::pos_t       position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

`default_nettype wire

>>> rtl/core/olist_out_if.sv
// Result channel of the ordered list.
`default_nettype none

interface olist_out_if;
  logic                  valid;
  logic                  ready;
  olist_pkg::value_t     removed_value;
  olist_pkg::status_t    status;
  olist_pkg::len_t       length;

  modport source (output valid, removed_value, status, length, input ready);
  modport sink   (input valid, removed_value, status, length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/olist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ordered_list_delete_at_position.sv
// Append: the result is valid in the cycle after the item is accepted; the next item may enter while it is taken.
// Rejected delete or full append: the result likewise follows acceptance in the next cycle.
// Valid delete at position p: S_HEAD takes the removed entry, then S_SHIFT moves one later
// entry up per cycle through the single RAM port pair until the list end is reached.
// Synchronous active-low reset empties the list and the result register;
// the RAM contents are not cleared, no entry at or past the length is read.
`default_nettype none
`include "ordered_list_delete_at_position_defines.svh"

module ordered_list_delete_at_position (
  input wire logic   clk,
  input wire logic   rst_n,
  olist_in_if.sink   in_ch,
  olist_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HEAD  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  olist_pkg::count_t      count_r, count_nxt;
  olist_pkg::count_t      ptr_r, ptr_nxt;      // next entry to read during shift
  olist_pkg::addr_t       lrd_r, lrd_nxt;      // address read in the previous cycle
  olist_pkg::value_t      removed_r, removed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  olist_pkg::value_t      out_value_r, out_value_nxt;
  olist_pkg::status_t     out_status_r, out_status_nxt;
  olist_pkg::len_t        out_len_r, out_len_nxt;

  logic                   ram_we, ram_re;
  olist_pkg::addr_t       ram_waddr, ram_raddr;
  olist_pkg::value_t      ram_wdata, ram_rdata;

  logic                   in_acc;
  logic                   pos_bad;

  olist_ram #(
    .WIDTH (olist_pkg::VAL_W),
    .DEPTH (olist_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pos_bad     = (in_ch.position == '0) ||
                       (32'(in_ch.position) > 32'(count_r));

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_value_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.length        = out_len_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    lrd_nxt        = lrd_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    ram_we         = 1'b0;
    ram_waddr      = lrd_r - 1'b1;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r[olist_pkg::ADDR_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = olist_pkg::NEG_ONE;
          out_len_nxt   = olist_pkg::LEN_W'(count_r);
          if (in_ch.opcode == olist_pkg::OP_APPEND) begin
            if (32'(count_r) == olist_pkg::DEPTH) begin
              out_status_nxt = olist_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = count_r[olist_pkg::ADDR_W-1:0];
              ram_wdata      = in_ch.value;
              count_nxt      = count_r + 1'b1;
              out_status_nxt = olist_pkg::ST_OK;
              out_len_nxt    = olist_pkg::LEN_W'(count_r + 1'b1);
            end
          end else if (pos_bad) begin
            out_status_nxt = olist_pkg::ST_INVALID;
          end else begin
            // hold the result until the later entries have moved up
            out_valid_nxt = 1'b0;
            ram_re        = 1'b1;
            ram_raddr     = olist_pkg::ADDR_W'(in_ch.position - 1'b1);
            ptr_nxt       = olist_pkg::CNT_W'(in_ch.position);
            state_nxt     = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        removed_nxt = ram_rdata;
        if (ptr_r < count_r) begin
          ram_re    = 1'b1;
          lrd_nxt   = ptr_r[olist_pkg::ADDR_W-1:0];
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          count_nxt      = count_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ram_rdata;
          out_status_nxt = olist_pkg::ST_OK;
          out_len_nxt    = olist_pkg::LEN_W'(count_r - 1'b1);
          state_nxt      = S_IDLE;
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves one place toward the head
        ram_we = 1'b1;
        if (ptr_r < count_r) begin
          ram_re  = 1'b1;
          lrd_nxt = ptr_r[olist_pkg::ADDR_W-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          count_nxt      = count_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = removed_r;
          out_status_nxt = olist_pkg::ST_OK;
          out_len_nxt    = olist_pkg::LEN_W'(count_r - 1'b1);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    lrd_r        <= lrd_nxt;
    removed_r    <= removed_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  `OL_ASSERT_NXT(a_append_grows,
    in_acc && (in_ch.opcode == olist_pkg::OP_APPEND) && (32'(count_r) < olist_pkg::DEPTH),
    count_r == $past(count_r) + 1'b1, "append did not grow the list")
  `OL_ASSERT_IMP(a_idle_write, ram_we && (state_r == S_IDLE),
    in_acc && (in_ch.opcode == olist_pkg::OP_APPEND), "store written in idle without an append")
  `OL_ASSERT_IMP(a_write_in_list, ram_we,
    32'(ram_waddr) < 32'(count_r) || state_r == S_IDLE, "shift wrote past the list end")
  `OL_ASSERT_IMP(a_busy_out_free, state_r != S_IDLE, !out_valid_r,
    "result register busy during a delete")
  `OL_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_r) <= olist_pkg::DEPTH,
    "list length above capacity")

endmodule

`default_nettype wire

>>> test/ordered_list_delete_at_position_test.sv
// Testbench for the ordered list block: append and delete-at-position checked against a model.
`timescale 1ns / 100ps

module ordered_list_delete_at_position_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = olist_pkg::DEPTH + 8;

  typedef struct {
    olist_pkg::value_t  removed_value;
    olist_pkg::status_t status;
    olist_pkg::len_t    length;
  } list_result_t;

  logic clk;
  logic rst_n;

  olist_in_if  in_if ();
  olist_out_if out_if ();

  ordered_list_delete_at_position DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Shadow copy of the list
  olist_pkg::value_t list_entries [olist_pkg::DEPTH];
  int     list_len;
  list_result_t pending_results [$];

  bit gaps_on;
  bit stalls_on;
  int stall_left;
  int error_count;
  int result_count;
  int append_count;
  int full_count;
  int delete_count;
  int reject_count;
  int peak_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one accepted item to the shadow list and queues the result it must give.
  task automatic list_apply(input logic op, input olist_pkg::value_t val,
                            input olist_pkg::pos_t pos);
    list_result_t r;
    int i;
    r.removed_value = olist_pkg::NEG_ONE;
    r.status = olist_pkg::ST_OK;
    if (op == olist_pkg::OP_APPEND) begin
      if (list_len >= olist_pkg::DEPTH) begin
        r.status = olist_pkg::ST_FULL;
        full_count++;
      end else begin
        list_entries[list_len] = val;
        list_len++;
        append_count++;
      end
    end else if (pos == 0 || int'(pos) > list_len) begin
      r.status = olist_pkg::ST_INVALID;
      reject_count++;
    end else begin
      r.removed_value = list_entries[int'(pos) - 1];
      for (i = int'(pos) - 1; i < list_len - 1; i++) list_entries[i] = list_entries[i + 1];
      list_len--;
      delete_count++;
    end
    r.length = olist_pkg::len_t'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    pending_results.push_back(r);
  endtask

  task automatic send_item(input logic op, input olist_pkg::value_t val,
                           input olist_pkg::pos_t pos);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.opcode   = op;
    in_if.value    = val;
    in_if.position = pos;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    list_apply(op, val, pos);
  endtask

  // The field that the operation ignores carries random junk.
  task automatic append_value(input olist_pkg::value_t val);
    send_item(olist_pkg::OP_APPEND, val, olist_pkg::pos_t'($urandom));
  endtask

  task automatic delete_at(input int pos);
    send_item(olist_pkg::OP_DELETE, olist_pkg::value_t'($urandom), olist_pkg::pos_t'(pos));
  endtask

  function automatic olist_pkg::value_t pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return olist_pkg::NEG_ONE;
      3: return '0;
      default: return olist_pkg::value_t'($urandom);
    endcase
  endfunction

  // Result side: random ready stalls in bursts.
  initial begin
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $time, what, result_count, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d length %0d", $time,
                 out_if.removed_value, out_if.status, out_if.length);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("removed_value", want.removed_value, out_if.removed_value);
        check_field("status", want.status, out_if.status);
        check_field("length", want.length, out_if.length);
      end
      result_count++;
    end
  end

  task automatic test_empty_list();
    delete_at(0);
    delete_at(1);
    delete_at(127);
  endtask

  task automatic test_value_extremes();
    append_value(32'sh7FFFFFFF);
    append_value(32'sh80000000);
    append_value('0);
    append_value(olist_pkg::NEG_ONE);
    append_value(32'sh55555555);
    append_value(32'shAAAAAAAA);
    delete_at(2);
    delete_at(5);
    delete_at(1);
  endtask

  task automatic test_bad_positions();
    delete_at(0);
    delete_at(list_len + 1);
    delete_at(64);
    delete_at(65);
    delete_at(127);
    delete_at(list_len);
  endtask

  task automatic test_full_list();
    while (list_len > 0) delete_at(1);
    repeat (olist_pkg::DEPTH) append_value(pick_value());
    repeat (3) append_value(pick_value());
    delete_at(olist_pkg::DEPTH);
    delete_at(olist_pkg::DEPTH + 1);
    append_value(pick_value());
    append_value(pick_value());
    delete_at(olist_pkg::DEPTH + 1);
    while (list_len > 0) delete_at($urandom_range(1, list_len));
  endtask

  // Segments lean toward growing or shrinking so the length sweeps its whole range.
  task automatic test_random_mix(input int n_items, input bit with_idle);
    int k;
    int append_pct;
    int pos;
    append_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 80 == 0) begin
        case ($urandom_range(0, 3))
          0: append_pct = 15;
          1: append_pct = 45;
          2: append_pct = 60;
          default: append_pct = 90;
        endcase
        gaps_on   = with_idle && $urandom_range(0, 3) != 0;
        stalls_on = with_idle && $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < append_pct) begin
        append_value(pick_value());
      end else begin
        case ($urandom_range(0, 9))
          0: pos = 0;
          1: pos = list_len + 1;
          2: pos = $urandom_range(0, 127);
          3: pos = 1;
          4: pos = list_len;
          default: pos = $urandom_range(1, (list_len > 0) ? list_len : 1);
        endcase
        delete_at(pos);
      end
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.opcode   = olist_pkg::OP_APPEND;
    in_if.value    = '0;
    in_if.position = '0;
    rst_n = 1'b0;
    list_len = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    error_count = 0;
    result_count = 0;
    append_count = 0;
    full_count = 0;
    delete_count = 0;
    reject_count = 0;
    peak_len = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_value_extremes();
    test_bad_positions();
    test_full_list();
    test_random_mix(1100, 1'b1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_mix(200, 1'b0);

    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d appends, %0d appends to a full list,",
             result_count, append_count, full_count);
    $display("%0d deletes, %0d rejected deletes; longest list %0d entries",
             delete_count, reject_count, peak_len);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
